### design/sbs_pkg.sv
// ----------------------------------------------------------------------------
// sbs_pkg
// Shared widths, operation codes and state type for the sorted table search.
// ----------------------------------------------------------------------------
package sbs_pkg;

  localparam int FUNC_W        = 1;
  localparam int INDEX_W       = 8;
  localparam int VALUE_W       = 32;
  localparam int KEY_W         = 16;
  localparam int ENTRY_COUNT_W = 9;

  localparam logic [FUNC_W-1:0] FUNC_WRITE  = 1'b0;
  localparam logic [FUNC_W-1:0] FUNC_SEARCH = 1'b1;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_PROBE,
    ST_DONE
  } sbs_state_t;

endpackage

### design/sbs_if.sv
// ----------------------------------------------------------------------------
// sbs_if
// Valid/ready channels of the sorted table search: request, result, config.
// ----------------------------------------------------------------------------
interface sbs_in_if;
  import sbs_pkg::*;

  logic                 valid;
  logic                 ready;
  logic [FUNC_W-1:0]    func;
  logic [INDEX_W-1:0]   entry_index;
  logic [VALUE_W-1:0]   entry_value;
  logic [KEY_W-1:0]     search_key;

  modport source (output valid, func, entry_index, entry_value, search_key,
                  input ready);
  modport sink   (input valid, func, entry_index, entry_value, search_key,
                  output ready);
endinterface

interface sbs_out_if;
  import sbs_pkg::*;

  logic                 valid;
  logic                 ready;
  logic                 found;
  logic [INDEX_W-1:0]   match_index;

  modport source (output valid, found, match_index, input ready);
  modport sink   (input valid, found, match_index, output ready);
endinterface

interface sbs_cfg_if;
  import sbs_pkg::*;

  logic                      valid;
  logic                      ready;
  logic [ENTRY_COUNT_W-1:0]  entry_count;

  modport source (output valid, entry_count, input ready);
  modport sink   (input valid, entry_count, output ready);
endinterface

### design/sbs_ram.sv
// ----------------------------------------------------------------------------
// sbs_ram
// Generic single-port synchronous RAM with registered read data.
// ----------------------------------------------------------------------------
module sbs_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 256
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] addr,
  input  logic [WIDTH-1:0]         wdata,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[addr] <= wdata;
    end
    rdata <= mem[addr];
  end

endmodule

### design/sbs_ctrl.sv
// ----------------------------------------------------------------------------
// sbs_ctrl
// Search sequencer: table loads, one probe per cycle, result register.
// ----------------------------------------------------------------------------
module sbs_ctrl #(
  parameter int TABLE_DEPTH = 256
) (
  input  logic                           clk,
  input  logic                           rst,
  sbs_in_if.sink                         req,
  sbs_cfg_if.sink                        cfg,
  sbs_out_if.source                      rsp,
  output logic                           ram_we,
  output logic [$clog2(TABLE_DEPTH)-1:0] ram_addr,
  output logic [sbs_pkg::VALUE_W-1:0]    ram_wdata,
  input  logic [sbs_pkg::VALUE_W-1:0]    ram_rdata
);
  import sbs_pkg::*;

  localparam int AW  = $clog2(TABLE_DEPTH);
  localparam int DCW = $clog2(TABLE_DEPTH + 1);
  localparam int CW  = (DCW > ENTRY_COUNT_W) ? DCW : ENTRY_COUNT_W;
  localparam logic [CW-1:0] DEPTH_C = CW'(TABLE_DEPTH);

  sbs_state_t state, state_next;

  logic [ENTRY_COUNT_W-1:0] entry_count;
  logic [CW-1:0]            count_sat;
  logic [CW-1:0]            low, low_next;
  logic [CW-1:0]            high_end, high_end_next;
  logic [AW-1:0]            mid, mid_next, mid_init;
  logic [KEY_W-1:0]         key;
  logic                     res_found;
  logic [INDEX_W-1:0]       res_index;
  logic                     req_acc;
  logic                     is_search;
  logic [CW-1:0]            widx;
  logic [CW-1:0]            mid_ext;
  logic [VALUE_W-1:0]       key_ext;
  logic                     key_lt, key_gt, hit, miss;
  logic                     rsp_free;

  function automatic logic [AW-1:0] mid_of(input logic [CW-1:0] lo,
                                           input logic [CW-1:0] hi_end);
    logic [CW:0] sum;
    sum = {1'b0, lo} + {1'b0, hi_end} - (CW+1)'(1);
    return sum[AW:1];
  endfunction

  assign req_acc   = req.valid && req.ready;
  assign is_search = (req.func == FUNC_SEARCH);
  assign count_sat = (CW'(entry_count) > DEPTH_C) ? DEPTH_C : CW'(entry_count);
  assign mid_init  = mid_of('0, count_sat);
  assign widx      = CW'(req.entry_index);
  assign mid_ext   = CW'(mid);
  assign key_ext   = VALUE_W'(key);
  assign key_lt    = key_ext < ram_rdata;
  assign key_gt    = key_ext > ram_rdata;
  assign hit       = !key_lt && !key_gt;
  assign low_next      = key_gt ? mid_ext + CW'(1) : low;
  assign high_end_next = key_lt ? mid_ext : high_end;
  assign miss      = low_next >= high_end_next;
  assign mid_next  = mid_of(low_next, high_end_next);
  assign rsp_free  = !rsp.valid || rsp.ready;
  assign cfg.ready = 1'b1;

  // next state
  always_comb begin
    state_next = state;
    case (state)
      ST_IDLE: begin
        if (req_acc && is_search) begin
          state_next = (count_sat == '0) ? ST_DONE : ST_PROBE;
        end
      end
      ST_PROBE: begin
        if (hit || miss) begin
          state_next = ST_DONE;
        end
      end
      ST_DONE: begin
        if (rsp_free) begin
          state_next = ST_IDLE;
        end
      end
      default: state_next = ST_IDLE;
    endcase
  end

  // outputs
  always_comb begin
    req.ready = 1'b0;
    ram_we    = 1'b0;
    ram_addr  = widx[AW-1:0];
    ram_wdata = req.entry_value;
    case (state)
      ST_IDLE: begin
        req.ready = 1'b1;
        if (is_search) begin
          ram_addr = mid_init;
        end else begin
          ram_we = req.valid && (widx < DEPTH_C);
        end
      end
      ST_PROBE: begin
        ram_addr = mid_next;
      end
      ST_DONE: begin
        ram_addr = mid;
      end
      default: begin
        req.ready = 1'b0;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state       <= ST_IDLE;
      entry_count <= '0;
      rsp.valid   <= 1'b0;
    end else begin
      state <= state_next;
      if (cfg.valid) begin
        entry_count <= cfg.entry_count;
      end
      if (state == ST_DONE && rsp_free) begin
        rsp.valid <= 1'b1;
      end else if (rsp.ready) begin
        rsp.valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (state == ST_IDLE && req_acc && is_search) begin
      low       <= '0;
      high_end  <= count_sat;
      mid       <= mid_init;
      key       <= req.search_key;
      res_found <= 1'b0;
      res_index <= '0;
    end else if (state == ST_PROBE) begin
      low      <= low_next;
      high_end <= high_end_next;
      mid      <= mid_next;
      if (hit) begin
        res_found <= 1'b1;
        res_index <= mid_ext[INDEX_W-1:0];
      end
    end
    if (state == ST_DONE && rsp_free) begin
      rsp.found       <= res_found;
      rsp.match_index <= res_index;
    end
  end

endmodule

### design/sorted_table_binary_search.sv
// ----------------------------------------------------------------------------
// sorted_table_binary_search
// Loadable table of 32-bit words with binary search of a 16-bit key.
//
//   channel  role    payload
//   req      sink    func, entry_index, entry_value, search_key
//   cfg      sink    entry_count
//   rsp      source  found, match_index
//
// a write transaction gives no result
// a search makes one probe per cycle on the single ram port,
// up to ceil(log2(entry_count + 1)) probes
// the engine leaves a search once the result register can take its result
// rst clears control and entry_count; table contents stay undefined until
// written, with no clearing pass
// ----------------------------------------------------------------------------
module sorted_table_binary_search #(
  parameter int TABLE_DEPTH = 256
) (
  input  logic      clk,
  input  logic      rst,
  sbs_in_if.sink    req,
  sbs_cfg_if.sink   cfg,
  sbs_out_if.source rsp
);
  import sbs_pkg::*;

  localparam int AW = $clog2(TABLE_DEPTH);

  logic               ram_we;
  logic [AW-1:0]      ram_addr;
  logic [VALUE_W-1:0] ram_wdata;
  logic [VALUE_W-1:0] ram_rdata;

  sbs_ram #(
    .WIDTH (VALUE_W),
    .DEPTH (TABLE_DEPTH)
  ) u_ram (
    .clk   (clk),
    .we    (ram_we),
    .addr  (ram_addr),
    .wdata (ram_wdata),
    .rdata (ram_rdata)
  );

  sbs_ctrl #(
    .TABLE_DEPTH (TABLE_DEPTH)
  ) u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .req       (req),
    .cfg       (cfg),
    .rsp       (rsp),
    .ram_we    (ram_we),
    .ram_addr  (ram_addr),
    .ram_wdata (ram_wdata),
    .ram_rdata (ram_rdata)
  );

endmodule

### design/sbs_check.sv
// ----------------------------------------------------------------------------
// sbs_check
// Port-level assertions for the sorted table search, bound to the top level.
// ----------------------------------------------------------------------------
module sbs_check (
  input logic                         clk,
  input logic                         rst,
  input logic                         req_valid,
  input logic                         req_ready,
  input logic [sbs_pkg::FUNC_W-1:0]   req_func,
  input logic                         rsp_valid,
  input logic                         rsp_ready,
  input logic                         rsp_found,
  input logic [sbs_pkg::INDEX_W-1:0]  rsp_match_index
);
  import sbs_pkg::*;

  a_rsp_hold: assert property (@(posedge clk) disable iff (rst)
    rsp_valid && !rsp_ready |=> rsp_valid)
    else $error("result dropped while stalled");

  a_miss_index: assert property (@(posedge clk) disable iff (rst)
    rsp_valid && !rsp_found |-> rsp_match_index == '0)
    else $error("miss with nonzero index");

  a_search_busy: assert property (@(posedge clk) disable iff (rst)
    req_valid && req_ready && req_func == FUNC_SEARCH |=> !req_ready)
    else $error("search transaction did not occupy the engine");

  a_write_ready: assert property (@(posedge clk) disable iff (rst)
    req_valid && req_ready && req_func == FUNC_WRITE |=> req_ready)
    else $error("write transaction stalled the request channel");

  a_rsp_after_busy: assert property (@(posedge clk) disable iff (rst)
    $rose(rsp_valid) |-> $past(!req_ready))
    else $error("result appeared without a search in progress");

endmodule

bind sorted_table_binary_search sbs_check u_check (
  .clk             (clk),
  .rst             (rst),
  .req_valid       (req.valid),
  .req_ready       (req.ready),
  .req_func        (req.func),
  .rsp_valid       (rsp.valid),
  .rsp_ready       (rsp.ready),
  .rsp_found       (rsp.found),
  .rsp_match_index (rsp.match_index)
);

### tb/sv/testbench.sv
// ----------------------------------------------------------------------------
// testbench
// Drives sorted_table_binary_search with table loads, entry count settings
// and key searches under random stalls on both channels. Every search is
// predicted from a private copy of the table and count, and each result is
// compared in order against the predicted found flag and index.
// ----------------------------------------------------------------------------
module testbench;
  timeunit 1ns;
  timeprecision 1ps;

  import sbs_pkg::*;

  localparam int TABLE_DEPTH = 256;
  localparam int ITEM_TARGET = 1650;
  localparam int SETTLE_CYCLES = 16;

  typedef struct packed {
    logic [FUNC_W-1:0]  func;
    logic [INDEX_W-1:0] entry_index;
    logic [VALUE_W-1:0] entry_value;
    logic [KEY_W-1:0]   search_key;
  } req_item_t;

  typedef struct packed {
    logic               found;
    logic [INDEX_W-1:0] match_index;
  } search_result_t;

  class search_scoreboard;
    logic [VALUE_W-1:0]       words [TABLE_DEPTH];
    logic [ENTRY_COUNT_W-1:0] live_count;
    search_result_t           awaited [$];
    int unsigned              mismatches;

    function new();
      live_count = '0;
      mismatches = 0;
    endfunction

    function void set_count(logic [ENTRY_COUNT_W-1:0] n);
      live_count = n;
    endfunction

    function search_result_t search(logic [KEY_W-1:0] key);
      search_result_t     r;
      int                 lo, hi, mid;
      logic [VALUE_W-1:0] wide_key;
      r = '0;
      wide_key = {{(VALUE_W-KEY_W){1'b0}}, key};
      lo = 0;
      hi = (live_count > TABLE_DEPTH ? TABLE_DEPTH : int'(live_count)) - 1;
      while (lo <= hi) begin
        mid = (lo + hi) / 2;
        if (wide_key < words[mid]) hi = mid - 1;
        else if (wide_key > words[mid]) lo = mid + 1;
        else begin
          r.found = 1'b1;
          r.match_index = mid[INDEX_W-1:0];
          return r;
        end
      end
      return r;
    endfunction

    function void note_request(req_item_t it);
      if (it.func == FUNC_WRITE) words[it.entry_index] = it.entry_value;
      else awaited.push_back(search(it.search_key));
    endfunction

    function void check_result(logic found, logic [INDEX_W-1:0] idx);
      search_result_t want;
      if (awaited.size() == 0) begin
        mismatches++;
        if (mismatches <= 10)
          $display("unexpected result: found=%0b index=%0d", found, idx);
        return;
      end
      want = awaited.pop_front();
      if (found !== want.found || idx !== want.match_index) begin
        mismatches++;
        if (mismatches <= 10)
          $display("mismatch: expected found=%0b index=%0d, got found=%0b index=%0d",
                   want.found, want.match_index, found, idx);
      end
    endfunction
  endclass

  logic clk;
  logic rst;
  int   items_sent = 0;

  search_scoreboard books = new();

  sbs_in_if  req_ch ();
  sbs_cfg_if cfg_ch ();
  sbs_out_if rsp_ch ();

  sorted_table_binary_search #(.TABLE_DEPTH(TABLE_DEPTH)) uut (
    .clk (clk),
    .rst (rst),
    .req (req_ch),
    .cfg (cfg_ch),
    .rsp (rsp_ch)
  );

  initial clk = 1'b0;
  always #5 clk = ~clk;

  initial begin
    #15_000_000;
    $display("testbench: FAIL");
    $finish;
  end

  function automatic int idle_gap();
    int r;
    r = $urandom_range(0, 99);
    if (r < 50) return 0;
    if (r < 85) return $urandom_range(1, 3);
    if (r < 97) return $urandom_range(4, 12);
    return $urandom_range(20, 60);
  endfunction

  task automatic send_req(input req_item_t it);
    int gap;
    gap = idle_gap();
    @(negedge clk);
    if (gap > 0) begin
      req_ch.valid = 1'b0;
      repeat (gap) @(negedge clk);
    end
    req_ch.valid       = 1'b1;
    req_ch.func        = it.func;
    req_ch.entry_index = it.entry_index;
    req_ch.entry_value = it.entry_value;
    req_ch.search_key  = it.search_key;
    do @(posedge clk); while (!req_ch.ready);
    books.note_request(it);
    items_sent++;
  endtask

  task automatic send_write(input logic [INDEX_W-1:0] idx, input logic [VALUE_W-1:0] val);
    req_item_t it;
    it.func        = FUNC_WRITE;
    it.entry_index = idx;
    it.entry_value = val;
    it.search_key  = KEY_W'($urandom_range(0, 16'hFFFF));
    send_req(it);
  endtask

  task automatic send_search(input logic [KEY_W-1:0] key);
    req_item_t it;
    it.func        = FUNC_SEARCH;
    it.entry_index = INDEX_W'($urandom_range(0, 255));
    it.entry_value = $urandom;
    it.search_key  = key;
    send_req(it);
  endtask

  task automatic end_burst();
    @(negedge clk);
    req_ch.valid = 1'b0;
  endtask

  // block must be idle before the count changes
  task automatic settle();
    end_burst();
    while (books.awaited.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic set_count(input logic [ENTRY_COUNT_W-1:0] n);
    settle();
    @(negedge clk);
    cfg_ch.valid       = 1'b1;
    cfg_ch.entry_count = n;
    do @(posedge clk); while (!cfg_ch.ready);
    books.set_count(n);
    @(negedge clk);
    cfg_ch.valid = 1'b0;
  endtask

  // ascending contents with duplicates, dense or sparse steps and rare big jumps
  task automatic load_sorted(input int n);
    logic [63:0] v;
    int          span;
    span = $urandom_range(0, 1) ? $urandom_range(1, 8) : $urandom_range(16, 2000);
    v = 64'($urandom_range(0, 64));
    for (int i = 0; i < n; i++) begin
      send_write(i[INDEX_W-1:0], v[VALUE_W-1:0]);
      case ($urandom_range(0, 19))
        0, 1: v = v;
        2: v += $urandom;
        default: v += $urandom_range(1, span);
      endcase
      if (v > 64'hFFFF_FFFF) v = 64'hFFFF_FFFF;
    end
  endtask

  initial begin
    int n, eff, mode, r;
    logic [KEY_W-1:0] key;
    logic [KEY_W-1:0] probes [7];
    probes = '{16'h0000, 16'h0005, 16'hFFFF, 16'h0003, 16'h0006, 16'hFFFE, 16'h8000};
    rst                = 1'b1;
    req_ch.valid       = 1'b0;
    req_ch.func        = FUNC_WRITE;
    req_ch.entry_index = '0;
    req_ch.entry_value = '0;
    req_ch.search_key  = '0;
    cfg_ch.valid       = 1'b0;
    cfg_ch.entry_count = '0;
    repeat (11) @(posedge clk);
    @(negedge clk);
    rst = 1'b0;

    // empty table straight out of reset
    send_search(16'h0000);
    send_write(8'd0, 32'h0000_0000);
    send_write(8'd1, 32'h0000_0005);
    send_write(8'd2, 32'h0000_FFFF);
    send_write(8'd3, 32'hFFFF_FFFF);
    set_count(9'd4);
    foreach (probes[i]) send_search(probes[i]);
    set_count(9'd1);
    send_search(16'h0000);
    send_search(16'h0001);
    set_count(9'd0);
    send_search(16'h0000);

    // fill the whole table so any count is legal from here on
    load_sorted(TABLE_DEPTH);

    while (items_sent < ITEM_TARGET) begin
      r = $urandom_range(0, 99);
      if (r < 5) n = 0;
      else if (r < 10) n = 1;
      else if (r < 14) n = TABLE_DEPTH;
      else if (r < 16) n = 511;
      else if (r < 20) n = $urandom_range(TABLE_DEPTH + 1, 510);
      else if (r < 30) n = $urandom_range(33, TABLE_DEPTH - 1);
      else n = $urandom_range(2, 32);
      eff = n > TABLE_DEPTH ? TABLE_DEPTH : n;

      mode = $urandom_range(0, 9);
      if (mode < 7 && (eff <= 64 || $urandom_range(0, 3) == 0)) load_sorted(eff);
      else if (mode == 9)
        repeat ($urandom_range(1, 8)) send_write(INDEX_W'($urandom_range(0, 255)), $urandom);
      set_count(n[ENTRY_COUNT_W-1:0]);

      repeat ($urandom_range(10, 40)) begin
        if ($urandom_range(0, 24) == 0)
          send_write(INDEX_W'($urandom_range(0, 255)), $urandom);
        r = $urandom_range(0, 99);
        if (eff > 0 && r < 50) key = books.words[$urandom_range(0, eff - 1)][KEY_W-1:0];
        else if (eff > 0 && r < 65)
          key = books.words[$urandom_range(0, eff - 1)][KEY_W-1:0] ^ 16'h0001;
        else if (r < 72) key = $urandom_range(0, 1) ? 16'hFFFF : 16'h0000;
        else key = KEY_W'($urandom_range(0, 16'hFFFF));
        send_search(key);
      end
    end

    end_burst();
    for (int w = 0; w < 200000 && books.awaited.size() != 0; w++) @(posedge clk);
    repeat (20) @(posedge clk);
    if (books.mismatches == 0 && books.awaited.size() == 0) begin
      $display("testbench: PASS");
    end else begin
      $display("testbench: FAIL");
    end
    $finish;
  end

  initial begin
    int hold;
    rsp_ch.ready = 1'b0;
    wait (rst == 1'b0);
    forever begin
      @(negedge clk);
      rsp_ch.ready = 1'b1;
      repeat ($urandom_range(0, 30)) @(negedge clk);
      hold = idle_gap();
      if (hold > 0) begin
        rsp_ch.ready = 1'b0;
        repeat (hold) @(negedge clk);
      end
    end
  end

  always @(posedge clk) begin
    if (rsp_ch.valid && rsp_ch.ready) books.check_result(rsp_ch.found, rsp_ch.match_index);
  end

endmodule

### sorted_table_binary_search.f
design/sbs_pkg.sv
design/sbs_if.sv
design/sbs_ram.sv
design/sbs_ctrl.sv
design/sorted_table_binary_search.sv
design/sbs_check.sv
tb/sv/testbench.sv
